// ===== design/pcd_pkg.sv =====
`timescale 1ns / 1ps
package pcd_pkg;

	localparam int unsigned CoordW     = 32;
	localparam int unsigned RadW       = 31;
	localparam int unsigned DiffW      = 33;
	localparam int unsigned MulW       = 66;
	localparam int unsigned SumW       = 68;
	localparam int unsigned RootW      = 33;
	localparam int unsigned RemW       = 36;
	localparam int unsigned SqrtSteps  = 33;
	localparam int unsigned FracBits   = 16;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned InDataW    = 352;
	localparam int unsigned InUserW    = 2;
	localparam int unsigned OutDataW   = 32;

	typedef enum logic [1:0] {
		KindSphereSphere = 2'd0,
		KindSphereWall   = 2'd1,
		KindNone         = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nz;
		logic [30:0]        r1;
		logic [30:0]        r2;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ===== design/pcd_front.sv =====
`timescale 1ns / 1ps
module pcd_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pcd_pkg::InDataW-1:0]      s_tdata,
	input  logic [pcd_pkg::InUserW-1:0]      s_tuser,
	output logic                             item_valid,
	input  logic                             item_ready,
	output pcd_pkg::item_t                   item
);

	logic                   valid_q;
	pcd_pkg::item_t         item_q;
	pcd_pkg::item_t         item_d;
	logic signed [31:0]     fx, fy, fz, sx, sy, sz;

	assign fx = s_tdata[31:0];
	assign fy = s_tdata[63:32];
	assign fz = s_tdata[95:64];
	assign sx = s_tdata[158:127];
	assign sy = s_tdata[190:159];
	assign sz = s_tdata[222:191];

	always_comb begin
		item_d.kind = s_tuser;
		item_d.dx   = {fx[31], fx} - {sx[31], sx};
		item_d.dy   = {fy[31], fy} - {sy[31], sy};
		item_d.dz   = {fz[31], fz} - {sz[31], sz};
		item_d.r1   = s_tdata[126:96];
		item_d.r2   = s_tdata[253:223];
		item_d.nx   = s_tdata[285:254];
		item_d.ny   = s_tdata[317:286];
		item_d.nz   = s_tdata[349:318];
	end

	assign s_tready   = !valid_q || item_ready;
	assign item_valid = valid_q;
	assign item       = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q <= item_d;
		end
	end

endmodule

// ===== design/pcd_queue.sv =====
`timescale 1ns / 1ps
module pcd_queue #(
	parameter int unsigned QueueDepth = pcd_pkg::QueueDepth
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	output logic                    push_ready,
	input  pcd_pkg::item_t          push_item,
	output logic                    pop_valid,
	input  logic                    pop_en,
	output pcd_pkg::item_t          pop_item,
	output pcd_pkg::queue_status_t  status
);

	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	pcd_pkg::item_t  mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign push_ready   = cnt_q != CntW'(QueueDepth);
	assign pop_valid    = cnt_q != '0;
	assign do_push      = push_valid && push_ready;
	assign do_pop       = pop_en && pop_valid;
	assign pop_item     = mem_q[rd_ptr_q];
	assign status.full  = !push_ready;
	assign status.empty = !pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== design/pcd_back.sv =====
`timescale 1ns / 1ps
module pcd_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_pop,
	input  pcd_pkg::item_t                   q_item,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pcd_pkg::OutDataW-1:0]     m_tdata,
	output logic [0:0]                       m_tuser
);

	localparam int unsigned SumW  = pcd_pkg::SumW;
	localparam int unsigned MulW  = pcd_pkg::MulW;
	localparam int unsigned RemW  = pcd_pkg::RemW;
	localparam int unsigned RootW = pcd_pkg::RootW;
	localparam int unsigned Steps = pcd_pkg::SqrtSteps;
	localparam logic signed [SumW-1:0] GapMax = {36'b0, 32'h7fffffff};
	localparam logic signed [SumW-1:0] GapMin = {{36{1'b1}}, 32'h80000000};

	logic en;

	// multiply stage
	logic signed [32:0]     mx, my, mz;
	logic signed [MulW-1:0] px, py, pz;
	logic                   valid_s1;
	logic [1:0]             kind_s1;
	logic signed [MulW-1:0] px_s1, py_s1, pz_s1;
	logic [30:0]            r1_s1, r2_s1;

	// sum stage
	logic signed [SumW-1:0] sum;
	logic                   valid_s2;
	logic [1:0]             kind_s2;
	logic [MulW-1:0]        rad_s2;
	logic signed [SumW-1:0] wall_s2;
	logic [31:0]            rsum_s2;

	// root stages
	logic                   sq_valid_q [Steps];
	logic [1:0]             sq_kind_q  [Steps];
	logic [MulW-1:0]        sq_rad_q   [Steps];
	logic signed [SumW-1:0] sq_wall_q  [Steps];
	logic [31:0]            sq_rsum_q  [Steps];
	logic [RemW-1:0]        sq_rem_q   [Steps];
	logic [RootW-1:0]       sq_root_q  [Steps];

	logic signed [SumW-1:0] gap_full;
	logic [31:0]            gap_sat;
	logic                   m_tvalid_q;
	logic [31:0]            gap_q;
	logic                   overlap_q;

	assign en    = !m_tvalid_q || m_tready;
	assign q_pop = en;

	always_comb begin
		if (q_item.kind == pcd_pkg::KindSphereWall) begin
			mx = {q_item.nx[31], q_item.nx};
			my = {q_item.ny[31], q_item.ny};
			mz = {q_item.nz[31], q_item.nz};
		end else begin
			mx = q_item.dx;
			my = q_item.dy;
			mz = q_item.dz;
		end
	end

	assign px = q_item.dx * mx;
	assign py = q_item.dy * my;
	assign pz = q_item.dz * mz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= q_item.kind;
			px_s1   <= px;
			py_s1   <= py;
			pz_s1   <= pz;
			r1_s1   <= q_item.r1;
			r2_s1   <= q_item.r2;
		end
	end

	assign sum = {{2{px_s1[MulW-1]}}, px_s1} + {{2{py_s1[MulW-1]}}, py_s1}
		+ {{2{pz_s1[MulW-1]}}, pz_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			rad_s2  <= sum[MulW-1:0];
			wall_s2 <= (sum >>> pcd_pkg::FracBits) - $signed({37'b0, r1_s1});
			rsum_s2 <= {1'b0, r1_s1} + {1'b0, r2_s1};
		end
	end

	for (genvar j = 0; j < Steps; j++) begin : g_sq
		logic                   pv;
		logic [1:0]             pk;
		logic [MulW-1:0]        prad;
		logic signed [SumW-1:0] pwall;
		logic [31:0]            prsum;
		logic [RemW-1:0]        prem;
		logic [RootW-1:0]       proot;
		logic [RemW-1:0]        cur, trial;
		logic                   fits;

		if (j == 0) begin : g_first
			assign pv    = valid_s2;
			assign pk    = kind_s2;
			assign prad  = rad_s2;
			assign pwall = wall_s2;
			assign prsum = rsum_s2;
			assign prem  = '0;
			assign proot = '0;
		end else begin : g_next
			assign pv    = sq_valid_q[j-1];
			assign pk    = sq_kind_q[j-1];
			assign prad  = sq_rad_q[j-1];
			assign pwall = sq_wall_q[j-1];
			assign prsum = sq_rsum_q[j-1];
			assign prem  = sq_rem_q[j-1];
			assign proot = sq_root_q[j-1];
		end

		assign cur   = {prem[RemW-3:0], prad[MulW-1-2*j -: 2]};
		assign trial = RemW'({proot, 2'b01});
		assign fits  = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_valid_q[j] <= 1'b0;
			end else if (en) begin
				sq_valid_q[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_kind_q[j] <= pk;
				sq_rad_q[j]  <= prad;
				sq_wall_q[j] <= pwall;
				sq_rsum_q[j] <= prsum;
				sq_rem_q[j]  <= fits ? cur - trial : cur;
				sq_root_q[j] <= {proot[RootW-2:0], fits};
			end
		end
	end

	always_comb begin
		unique case (sq_kind_q[Steps-1])
			pcd_pkg::KindSphereSphere: begin
				gap_full = $signed({35'b0, sq_root_q[Steps-1]})
					- $signed({36'b0, sq_rsum_q[Steps-1]});
			end
			pcd_pkg::KindSphereWall: begin
				gap_full = sq_wall_q[Steps-1];
			end
			default: begin
				gap_full = '0;
			end
		endcase
		if (gap_full > GapMax) begin
			gap_sat = GapMax[31:0];
		end else if (gap_full < GapMin) begin
			gap_sat = GapMin[31:0];
		end else begin
			gap_sat = gap_full[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= sq_valid_q[Steps-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gap_q     <= gap_sat;
			overlap_q <= gap_sat[31];
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = gap_q;
	assign m_tuser[0] = overlap_q;

endmodule

// ===== design/particle_contact_distance_top.sv =====
`timescale 1ns / 1ps
// channel  dir  tdata                                       tuser
// s_*      in   first_x/y/z, first_radius, second_x/y/z,    req_type
//               second_radius, normal_x/y/z
// m_*      out  gap                                         overlap
//
// one pair per cycle sustained while m_* is not stalled; pipeline from s_* transaction to m_tvalid
// (front register, queue write, multiply, sum, 33 root digit stages, output register)
// arst_n clears all valid flags and queue pointers
// a stall on m_* freezes the back pipeline; the queue and front keep taking pairs
// until the queue fills
module particle_contact_distance_top #(
	parameter int unsigned QueueDepth = pcd_pkg::QueueDepth
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// first_x, first_y, first_z, first_radius, second_x, second_y, second_z,
	// second_radius, normal_x, normal_y, normal_z, zero pad
	input  logic [pcd_pkg::InDataW-1:0]     s_tdata,
	// req_type
	input  logic [pcd_pkg::InUserW-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// gap
	output logic [pcd_pkg::OutDataW-1:0]    m_tdata,
	// overlap
	output logic [0:0]                      m_tuser
);

	logic                   item_valid, item_ready;
	pcd_pkg::item_t         item;
	logic                   q_valid, q_pop;
	pcd_pkg::item_t         q_item;
	pcd_pkg::queue_status_t qstat;

	pcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	pcd_queue #(
		.QueueDepth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (item_valid),
		.push_ready (item_ready),
		.push_item  (item),
		.pop_valid  (q_valid),
		.pop_en     (q_pop),
		.pop_item   (q_item),
		.status     (qstat)
	);

	pcd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_overlap_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] == m_tdata[31]))
		else $error("overlap flag disagrees with gap sign");

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue both full and empty");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !item_ready)
		else $error("push accepted while queue full");

endmodule

// ===== sim/tb_particle_contact_distance_top.sv =====
`timescale 1ns / 1ps
module tb_particle_contact_distance_top;

	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] ax, ay, az;
		logic [30:0]        ra;
		logic signed [31:0] bx, by, bz;
		logic [30:0]        rb;
		logic signed [31:0] nx, ny, nz;
	} pair_t;

	typedef struct {
		logic [31:0] gap;
		logic        overlap;
	} gap_t;

	int errors = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [32:0] isqrt(input logic [67:0] n);
		logic [32:0] r;
		logic [32:0] c;
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			c = r | (33'd1 << b);
			if ({35'd0, c} * {35'd0, c} <= n)
				r = c;
		end
		return r;
	endfunction

	function automatic gap_t contact_gap(input pair_t p);
		logic signed [33:0] d [3];
		logic signed [31:0] nrm [3];
		logic [67:0] sq;
		logic signed [71:0] dot;
		logic signed [71:0] g;
		gap_t res;
		d[0] = p.ax - p.bx;
		d[1] = p.ay - p.by;
		d[2] = p.az - p.bz;
		nrm[0] = p.nx;
		nrm[1] = p.ny;
		nrm[2] = p.nz;
		g = 0;
		if (p.kind == pcd_pkg::KindSphereSphere) begin
			sq = 0;
			for (int i = 0; i < 3; i++)
				sq += 68'(d[i]) * 68'(d[i]);
			g = $signed({39'd0, isqrt(sq)}) - $signed({41'd0, p.ra}) - $signed({41'd0, p.rb});
		end else if (p.kind == pcd_pkg::KindSphereWall) begin
			dot = 0;
			for (int i = 0; i < 3; i++)
				dot += 72'(d[i]) * 72'(nrm[i]);
			g = (dot >>> pcd_pkg::FracBits) - $signed({41'd0, p.ra});
		end
		if (g > 72'sd2147483647)
			g = 72'sd2147483647;
		else if (g < -72'sd2147483648)
			g = -72'sd2147483648;
		res.gap = g[31:0];
		res.overlap = g < 0;
		return res;
	endfunction

	class gap_scoreboard;
		gap_t pending[$];
		int checked = 0;

		function void note_pair(pair_t p);
			pending.push_back(contact_gap(p));
		endfunction

		task check_gap(logic [31:0] gap, logic overlap);
			gap_t e;
			if (pending.size() == 0) begin
				report("unexpected transaction", gap, 32'd0);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (gap !== e.gap)
				report("gap", gap, e.gap);
			if (overlap !== e.overlap)
				report("overlap", {31'd0, overlap}, {31'd0, e.overlap});
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [pcd_pkg::InDataW-1:0] s_tdata = '0;
	logic [pcd_pkg::InUserW-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [pcd_pkg::OutDataW-1:0] m_tdata;
	logic [0:0] m_tuser;
	bit quiet = 0;
	bit done = 0;
	int kinds_seen[4];

	gap_scoreboard sb = new();

	particle_contact_distance_top uut (.*);

	always #5 clk = ~clk;

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_gap(m_tdata, m_tuser[0]);

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 19);
				m_tready <= 0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1;
		end
	end

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] rnd_radius();
		case ($urandom_range(0, 3))
			0: return 31'h7fff_ffff;
			1: return 31'(($urandom_range(0, 32'h0004_0000)));
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic send_pair(input pair_t p);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= p.kind;
		s_tdata <= {2'd0, p.nz, p.ny, p.nx, p.rb, p.bz, p.by, p.bx, p.ra, p.az, p.ay, p.ax};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_pair(p);
		kinds_seen[p.kind]++;
		@(negedge clk);
	endtask

	function automatic pair_t make_pair(input logic [1:0] kind, input logic [31:0] c,
			input logic [30:0] r);
		pair_t p;
		p.kind = kind;
		p.ax = c; p.ay = c; p.az = c; p.ra = r;
		p.bx = ~c; p.by = ~c; p.bz = ~c; p.rb = r;
		p.nx = c; p.ny = c; p.nz = c;
		return p;
	endfunction

	initial begin
		pair_t p;
		int wait_cycles;
		repeat (7) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		for (int k = 0; k < 4; k++) begin
			send_pair(make_pair(2'(k), 32'h8000_0000, 31'h7fff_ffff));
			send_pair(make_pair(2'(k), 32'h7fff_ffff, 31'd0));
			send_pair(make_pair(2'(k), 32'h0000_0000, 31'd0));
			send_pair(make_pair(2'(k), 32'hffff_ffff, 31'h0001_0000));
		end
		p = make_pair(pcd_pkg::KindSphereWall, 32'h0003_0000, 31'h0001_0000);
		p.bx = 0; p.by = 0; p.bz = 0;
		p.nx = 32'h0001_0000; p.ny = 0; p.nz = 0;
		send_pair(p);
		p.nx = 32'hffff_0001;
		send_pair(p);
		p.kind = pcd_pkg::KindSphereSphere;
		p.ay = 32'h0004_0000; p.az = 0; p.ax = 32'h0003_0000;
		send_pair(p);
		for (int i = 0; i < 1000; i++) begin
			if (i == 850)
				quiet = 1;
			p.kind = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
				: 2'($urandom_range(0, 1));
			p.ax = rnd_coord(); p.ay = rnd_coord(); p.az = rnd_coord();
			p.bx = rnd_coord(); p.by = rnd_coord(); p.bz = rnd_coord();
			p.ra = rnd_radius(); p.rb = rnd_radius();
			p.nx = rnd_coord(); p.ny = rnd_coord(); p.nz = rnd_coord();
			if (p.kind == pcd_pkg::KindSphereWall && $urandom_range(0, 1))
				case ($urandom_range(0, 2))
					0: begin
						p.nx = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
						p.ny = 0; p.nz = 0;
					end
					1: begin
						p.ny = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
						p.nx = 0; p.nz = 0;
					end
					default: begin
						p.nz = 32'h0000_93cd; p.nx = 32'h0000_93cd; p.ny = 32'hffff_6c33;
					end
				endcase
			send_pair(p);
		end
		s_tvalid <= 0;
		wait_cycles = 0;
		while (sb.pending.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (50) @(posedge clk);
		$display("checked %0d results; kinds sphere-sphere %0d, sphere-wall %0d, other %0d",
			sb.checked, kinds_seen[0], kinds_seen[1], kinds_seen[2] + kinds_seen[3]);
		if (errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else begin
			if (sb.pending.size() != 0)
				$display("%0d expected results never arrived", sb.pending.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
design/pcd_pkg.sv
design/pcd_front.sv
design/pcd_queue.sv
design/pcd_back.sv
design/particle_contact_distance_top.sv
sim/tb_particle_contact_distance_top.sv
